// ===== hw/rtl/des_pkg.sv =====
// ----------------------------------------------------------------------------
// des_pkg
// Shared types and constants of the delayed event scheduler.
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned DIM_W  = 8;
  localparam int unsigned DLY_W  = 16;
  localparam int unsigned PAY_W  = 64;
  localparam int unsigned TICK_W = 40;
  localparam int unsigned DUE_W  = TICK_W + 1;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned PEND_W = 6;
  // operand width of the shared adder; the result carries one extra bit
  localparam int unsigned ALU_W  = DUE_W;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic {
    KIND_EVENT  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [ALU_W-1:0]  a;
    logic [ALU_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic [DUE_W-1:0]  due;
    logic [DIM_W-1:0]  dim;
    logic [SEQ_W-1:0]  seq;
    logic [PAY_W-1:0]  payload;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEQ,
    ST_GAP,
    ST_DIM,
    ST_NOW,
    ST_FIND,
    ST_WRITE,
    ST_FULL,
    ST_SCAN,
    ST_CMP,
    ST_EMIT,
    ST_STATUS
  } state_e;

endpackage

// ===== hw/rtl/des_ram.sv =====
// ----------------------------------------------------------------------------
// des_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module des_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/des_alu.sv =====
// ----------------------------------------------------------------------------
// des_alu
// Shared adder/subtractor used for sequence checks, drop counting,
// due-tick computation and due compares.
// ----------------------------------------------------------------------------
module des_alu (
  input  des_pkg::alu_req_t          req_i,
  output logic [des_pkg::ALU_W:0]    res_o
);

  // top bit is carry on add, borrow on subtract
  always_comb begin
    unique case (req_i.op)
      des_pkg::ALU_ADD: res_o = {1'b0, req_i.a} + {1'b0, req_i.b};
      des_pkg::ALU_SUB: res_o = {1'b0, req_i.a} - {1'b0, req_i.b};
      default:          res_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/delayed_event_scheduler.sv =====
// ----------------------------------------------------------------------------
// delayed_event_scheduler
// Takes event requests and tick requests, one at a time. An event is checked
// against the expected sequence number (stale events vanish, gaps add to a
// saturating drop count) and the listener's dimension, then played at once
// or parked in the lowest free delay slot until current tick plus delay; a
// full slot table counts as a drop. A tick walks the slots from slot 0,
// frees every due slot, plays those of the listener's dimension and ends
// with a status result. Sequence checks, drop counting, due ticks and due
// compares share one 41-bit adder/subtractor, and slot contents sit in a
// RAM with one registered read port. An event passes the sequence check,
// the drop count update and the dimension check, then either loads the
// output register or searches the slots in order and writes the first free
// one. A tick visits each slot in turn and reads only busy ones from the RAM.
// A result waits while the output register is full and out_ready_i is low.
// The request side is ready only while the block is idle. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module delayed_event_scheduler #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [des_pkg::SEQ_W-1:0]           event_seq_i,
  input  logic signed [des_pkg::DIM_W-1:0]    event_dimension_i,
  input  logic [des_pkg::DLY_W-1:0]           delay_i,
  input  logic [des_pkg::PAY_W-1:0]           event_payload_i,
  input  logic [des_pkg::TICK_W-1:0]          current_tick_i,
  input  logic signed [des_pkg::DIM_W-1:0]    current_dimension_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                kind_o,
  output logic                                last_o,
  output logic [des_pkg::SEQ_W-1:0]           play_seq_o,
  output logic [des_pkg::PAY_W-1:0]           play_payload_o,
  output logic [des_pkg::CNT_W-1:0]           dropped_total_o,
  output logic [des_pkg::PEND_W-1:0]          pending_total_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  des_pkg::state_e state_q, state_d;
  logic [IW-1:0]               idx_q, idx_d;
  logic [des_pkg::SEQ_W-1:0]   exp_q, exp_d;
  logic [des_pkg::CNT_W-1:0]   drop_q, drop_d;
  logic [des_pkg::SEQ_W-1:0]   gap_q, gap_d;
  logic [des_pkg::PEND_W-1:0]  pend_q, pend_d;
  logic [SLOTS-1:0]            busy_q, busy_d;

  // captured request fields
  logic [des_pkg::SEQ_W-1:0]   seq_q;
  logic [des_pkg::DIM_W-1:0]   edim_q;
  logic [des_pkg::DLY_W-1:0]   dly_q;
  logic [des_pkg::PAY_W-1:0]   pay_q;
  logic [des_pkg::TICK_W-1:0]  tick_q;
  logic [des_pkg::DIM_W-1:0]   cdim_q;

  // output register
  logic                        out_valid_q;
  logic                        out_kind_q;
  logic                        out_last_q;
  logic [des_pkg::SEQ_W-1:0]   out_seq_q;
  logic [des_pkg::PAY_W-1:0]   out_pay_q;
  logic [des_pkg::CNT_W-1:0]   out_drop_q;
  logic [des_pkg::PEND_W-1:0]  out_pend_q;

  logic                        out_load;
  logic                        out_kind_d;
  logic                        out_last_d;
  logic [des_pkg::SEQ_W-1:0]   out_seq_d;
  logic [des_pkg::PAY_W-1:0]   out_pay_d;
  logic                        out_free;

  des_pkg::alu_req_t           alu_req;
  logic [des_pkg::ALU_W:0]     alu_res;

  logic                        ram_we;
  logic                        ram_re;
  des_pkg::slot_t              wr_slot;
  des_pkg::slot_t              rd_slot;

  logic                        in_accept;

  des_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  des_ram #(
    .WIDTH ($bits(des_pkg::slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (wr_slot),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (rd_slot)
  );

  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  assign wr_slot.due     = alu_res[des_pkg::DUE_W-1:0];
  assign wr_slot.dim     = edim_q;
  assign wr_slot.seq     = seq_q;
  assign wr_slot.payload = pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= des_pkg::ST_IDLE;
      idx_q   <= '0;
      exp_q   <= '0;
      drop_q  <= '0;
      gap_q   <= '0;
      pend_q  <= '0;
      busy_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      exp_q   <= exp_d;
      drop_q  <= drop_d;
      gap_q   <= gap_d;
      pend_q  <= pend_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      seq_q  <= event_seq_i;
      edim_q <= event_dimension_i;
      dly_q  <= delay_i;
      pay_q  <= event_payload_i;
      tick_q <= current_tick_i;
      cdim_q <= current_dimension_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_last_q <= out_last_d;
      out_seq_q  <= out_seq_d;
      out_pay_q  <= out_pay_d;
      out_drop_q <= drop_q;
      out_pend_q <= pend_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    exp_d      = exp_q;
    drop_d     = drop_q;
    gap_d      = gap_q;
    pend_d     = pend_q;
    busy_d     = busy_q;
    alu_req    = '{op: des_pkg::ALU_ADD, a: '0, b: '0};
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    out_load   = 1'b0;
    out_kind_d = des_pkg::KIND_EVENT;
    out_last_d = 1'b0;
    out_seq_d  = seq_q;
    out_pay_d  = pay_q;
    in_ready_o = 1'b0;

    unique case (state_q)
      des_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        idx_d      = '0;
        if (in_valid_i) begin
          state_d = (operation_i == des_pkg::OP_TICK) ? des_pkg::ST_SCAN : des_pkg::ST_SEQ;
        end
      end

      des_pkg::ST_SEQ: begin
        alu_req.op = des_pkg::ALU_SUB;
        alu_req.a  = des_pkg::ALU_W'(seq_q);
        alu_req.b  = des_pkg::ALU_W'(exp_q);
        if (alu_res[des_pkg::ALU_W]) begin
          // stale: drop without count
          state_d = des_pkg::ST_IDLE;
        end else begin
          gap_d   = alu_res[des_pkg::SEQ_W-1:0];
          exp_d   = seq_q + des_pkg::SEQ_W'(1);
          state_d = des_pkg::ST_GAP;
        end
      end

      des_pkg::ST_GAP: begin
        alu_req.a = des_pkg::ALU_W'(drop_q);
        alu_req.b = des_pkg::ALU_W'(gap_q);
        drop_d    = alu_res[des_pkg::CNT_W] ? '1 : alu_res[des_pkg::CNT_W-1:0];
        state_d   = des_pkg::ST_DIM;
      end

      des_pkg::ST_DIM: begin
        if (edim_q != cdim_q) begin
          state_d = des_pkg::ST_IDLE;
        end else if (dly_q == '0) begin
          state_d = des_pkg::ST_NOW;
        end else begin
          state_d = des_pkg::ST_FIND;
        end
      end

      des_pkg::ST_NOW: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = 1'b1;
          state_d    = des_pkg::ST_IDLE;
        end
      end

      des_pkg::ST_FIND: begin
        if (!busy_q[idx_q]) begin
          state_d = des_pkg::ST_WRITE;
        end else if (idx_q == LAST_IDX) begin
          state_d = des_pkg::ST_FULL;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      des_pkg::ST_WRITE: begin
        alu_req.a     = des_pkg::ALU_W'(tick_q);
        alu_req.b     = des_pkg::ALU_W'(dly_q);
        ram_we        = 1'b1;
        busy_d[idx_q] = 1'b1;
        pend_d        = pend_q + des_pkg::PEND_W'(1);
        state_d       = des_pkg::ST_IDLE;
      end

      des_pkg::ST_FULL: begin
        alu_req.a = des_pkg::ALU_W'(drop_q);
        alu_req.b = des_pkg::ALU_W'(1);
        drop_d    = alu_res[des_pkg::CNT_W] ? '1 : alu_res[des_pkg::CNT_W-1:0];
        state_d   = des_pkg::ST_IDLE;
      end

      des_pkg::ST_SCAN: begin
        if (busy_q[idx_q]) begin
          ram_re  = 1'b1;
          state_d = des_pkg::ST_CMP;
        end else if (idx_q == LAST_IDX) begin
          state_d = des_pkg::ST_STATUS;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      des_pkg::ST_CMP: begin
        alu_req.op = des_pkg::ALU_SUB;
        alu_req.a  = des_pkg::ALU_W'(tick_q);
        alu_req.b  = rd_slot.due;
        if (!alu_res[des_pkg::ALU_W]) begin
          // due: free the slot, play it if the dimension matches
          busy_d[idx_q] = 1'b0;
          pend_d        = pend_q - des_pkg::PEND_W'(1);
        end
        if (!alu_res[des_pkg::ALU_W] && rd_slot.dim == cdim_q) begin
          state_d = des_pkg::ST_EMIT;
        end else if (idx_q == LAST_IDX) begin
          state_d = des_pkg::ST_STATUS;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = des_pkg::ST_SCAN;
        end
      end

      des_pkg::ST_EMIT: begin
        out_seq_d = rd_slot.seq;
        out_pay_d = rd_slot.payload;
        if (out_free) begin
          out_load = 1'b1;
          if (idx_q == LAST_IDX) begin
            state_d = des_pkg::ST_STATUS;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = des_pkg::ST_SCAN;
          end
        end
      end

      des_pkg::ST_STATUS: begin
        out_kind_d = des_pkg::KIND_STATUS;
        out_last_d = 1'b1;
        out_seq_d  = '0;
        out_pay_d  = '0;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = des_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = des_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign last_o          = out_last_q;
  assign play_seq_o      = out_seq_q;
  assign play_payload_o  = out_pay_q;
  assign dropped_total_o = out_drop_q;
  assign pending_total_o = out_pend_q;

`ifndef SYNTHESIS
  a_pend_matches_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == des_pkg::PEND_W'($countones(busy_q)))
    else $error("pending count out of step with busy slots");

  a_drop_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 drop_q >= $past(drop_q))
    else $error("drop count decreased");

  a_cmp_reads_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == des_pkg::ST_CMP |-> busy_q[idx_q])
    else $error("compare on a free slot");

  a_write_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !busy_q[idx_q])
    else $error("insert into a busy slot");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");
`endif

endmodule
